FILE: rtl/best_fit_slab_cache_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the slab cache unit
// Clocked property checks, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_SLAB_CACHE_UNIT_MACROS_SVH
`define BEST_FIT_SLAB_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle property check
`define BFSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication
`define BFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFSC_ASSERT(label, clk, rst_n, prop, msg)
`define BFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/bfsc_pkg.sv
// ---------------------------------------------------------------------------
// bfsc_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bfsc_pkg;

  localparam int unsigned ENTRIES   = 8;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam logic [31:0] CAP_RESET = 32'd16 << 20;

  // request codes
  localparam logic [1:0] FUNC_TAKE  = 2'd0;
  localparam logic [1:0] FUNC_PUT   = 2'd1;
  localparam logic [1:0] FUNC_DRAIN = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_MISS   = 3'd1;
  localparam logic [2:0] KIND_STORED = 3'd2;
  localparam logic [2:0] KIND_REJECT = 3'd3;
  localparam logic [2:0] KIND_DRAIN  = 3'd4;

  // which result the datapath builds
  typedef enum logic [1:0] {
    RES_TAKE,
    RES_PUT,
    RES_DRAIN
  } bfsc_res_e;

  typedef struct packed {
    logic      accept;   // input transfer this cycle
    logic      idx_clr;
    logic      idx_inc;
    logic      scan_rd;  // scan read issued, compare next cycle
    logic      rd_best;  // port A addresses the best slot
    logic      emit;     // load output register
    bfsc_res_e res;
  } bfsc_cmd_t;

  typedef struct packed {
    logic used_zero;
    logic idx_last;
    logic out_free;
  } bfsc_sts_t;

endpackage

FILE: rtl/best_fit_slab_cache_unit.sv
// ---------------------------------------------------------------------------
// best_fit_slab_cache_unit
// Eight-entry recycle bin of free slabs with best-fit take and byte cap.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the operation
//   (take, put, drain), tdata the slab size and the offered handle. Results
//   leave on m_axis: tuser is the result kind, tdata the handle and size,
//   tlast marks the final result of a request. cfg_we_i writes the byte cap.
// Timing:
//   One request is worked at a time; s_axis_tready is high only when the
//   sequencer is idle. A put loads its result once the output register is
//   free. A take reads the store through one port, one slot per cycle, then
//   reads the best slot for its result. A drain reads each slot and emits
//   its release when the register frees; an empty bin drain returns nothing.
// Stalls and reset:
//   Results sit in an output register; a new request is accepted while the
//   last result still waits. If m_axis_tready stays low, the sequencer holds
//   its next result until the register frees. Reset empties the bin, sets the
//   cap to 16 MiB and clears the output valid; store contents are not reset.
// ---------------------------------------------------------------------------
module best_fit_slab_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte cap register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] slab_bytes, [63:32] block_handle
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] out_handle, [63:32] out_bytes
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  bfsc_pkg::bfsc_cmd_t cmd;
  bfsc_pkg::bfsc_sts_t sts;
  logic [31:0]         res_handle, res_bytes;

  // sequencer
  bfsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_func_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // store, totals and output register
  bfsc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_bytes_i   (s_axis_tdata[31:0]),
    .in_handle_i  (s_axis_tdata[63:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_handle_o (res_handle),
    .out_bytes_o  (res_bytes),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {res_bytes, res_handle};

endmodule

FILE: rtl/bfsc_ctrl.sv
// ---------------------------------------------------------------------------
// bfsc_ctrl
// Sequencer for take scan, put check and drain walk.
// ---------------------------------------------------------------------------
module bfsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic [1:0]          s_func_i,
  output logic                s_ready_o,
  input  bfsc_pkg::bfsc_sts_t sts_i,
  output bfsc_pkg::bfsc_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SDRN = 3'd2;  // last compare in flight
  localparam logic [2:0] ST_PICK = 3'd3;  // read best and tail slot
  localparam logic [2:0] ST_TEND = 3'd4;
  localparam logic [2:0] ST_PUT  = 3'd5;
  localparam logic [2:0] ST_DRD  = 3'd6;
  localparam logic [2:0] ST_DEM  = 3'd7;

  logic [2:0] state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res      = bfsc_pkg::RES_TAKE;
    cmd_o.accept   = s_valid_i && (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          unique case (s_func_i)
            bfsc_pkg::FUNC_TAKE: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_SCAN;
            end
            bfsc_pkg::FUNC_PUT: state_d = ST_PUT;
            bfsc_pkg::FUNC_DRAIN: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_DRD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.used_zero) begin
          state_d = ST_TEND;
        end else begin
          cmd_o.scan_rd = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_SDRN;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_SDRN: state_d = ST_PICK;
      ST_PICK: begin
        cmd_o.rd_best = 1'b1;
        state_d       = ST_TEND;
      end
      ST_TEND: begin
        cmd_o.rd_best = 1'b1;
        cmd_o.res     = bfsc_pkg::RES_TAKE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_PUT: begin
        cmd_o.res = bfsc_pkg::RES_PUT;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DRD: begin
        state_d = sts_i.used_zero ? ST_IDLE : ST_DEM;
      end
      ST_DEM: begin
        cmd_o.res = bfsc_pkg::RES_DRAIN;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_DRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/bfsc_dp.sv
// ---------------------------------------------------------------------------
// bfsc_dp
// Slab store, occupancy and byte totals, best-fit compare, output register.
// ---------------------------------------------------------------------------
`include "best_fit_slab_cache_unit_macros.svh"

module bfsc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [31:0]         in_bytes_i,
  input  logic [31:0]         in_handle_i,
  input  bfsc_pkg::bfsc_cmd_t cmd_i,
  output bfsc_pkg::bfsc_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_kind_o,
  output logic [31:0]         out_handle_o,
  output logic [31:0]         out_bytes_o,
  output logic                out_last_o
);

  localparam int unsigned IW = bfsc_pkg::IDX_W;
  localparam int unsigned CW = bfsc_pkg::CNT_W;

  // slab store: {handle, bytes}
  logic [63:0] slot_mem [bfsc_pkg::ENTRIES];
  logic [63:0] rd_a_q, rd_b_q;
  logic [IW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [63:0]   wr_data;
  logic          wr_en;

  logic [CW-1:0] used_q;
  logic [31:0]   held_q, cap_q;
  logic [31:0]   req_bytes_q, req_handle_q;
  logic [IW-1:0] idx_q, cmp_idx_q, best_idx_q;
  logic          cmp_vld_q, found_q;
  logic [31:0]   fit_size_q;
  logic [31:0]   cand_size;
  logic          better;
  logic          reject;
  logic [32:0]   put_sum;

  logic          out_valid_q, out_last_q;
  logic [2:0]    out_kind_q;
  logic [31:0]   out_handle_q, out_bytes_q;
  logic [2:0]    kind_d;
  logic [31:0]   handle_d, bytes_d;
  logic          last_d;

  assign sts_o.used_zero = (used_q == '0);
  assign sts_o.idx_last  = ((CW'(idx_q) + CW'(1)) == used_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign rd_a_addr = cmd_i.rd_best ? best_idx_q : idx_q;
  assign rd_b_addr = IW'(used_q - CW'(1));

  // cap test over 33 bits, no wrap
  assign put_sum = {1'b0, held_q} + {1'b0, req_bytes_q};
  assign reject  = (used_q == CW'(bfsc_pkg::ENTRIES)) || (put_sum > {1'b0, cap_q});

  assign cand_size = rd_a_q[31:0];
  assign better    = (cand_size >= req_bytes_q) && (!found_q || (cand_size < fit_size_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_data = rd_b_q;
    if (cmd_i.emit && (cmd_i.res == bfsc_pkg::RES_TAKE) && found_q) begin
      wr_en = 1'b1;
    end else if (cmd_i.emit && (cmd_i.res == bfsc_pkg::RES_PUT) && !reject) begin
      wr_en   = 1'b1;
      wr_addr = IW'(used_q);
      wr_data = {req_handle_q, req_bytes_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= slot_mem[rd_a_addr];
    rd_b_q <= slot_mem[rd_b_addr];
  end

  // result payload
  always_comb begin
    kind_d   = bfsc_pkg::KIND_MISS;
    handle_d = '0;
    bytes_d  = '0;
    last_d   = 1'b1;
    case (cmd_i.res)
      bfsc_pkg::RES_TAKE: begin
        if (found_q) begin
          kind_d   = bfsc_pkg::KIND_HIT;
          handle_d = rd_a_q[63:32];
          bytes_d  = fit_size_q;
        end
      end
      bfsc_pkg::RES_PUT: begin
        if (reject) begin
          kind_d   = bfsc_pkg::KIND_REJECT;
          handle_d = req_handle_q;
          bytes_d  = req_bytes_q;
        end else begin
          kind_d = bfsc_pkg::KIND_STORED;
        end
      end
      bfsc_pkg::RES_DRAIN: begin
        kind_d   = bfsc_pkg::KIND_DRAIN;
        handle_d = rd_a_q[63:32];
        bytes_d  = rd_a_q[31:0];
        last_d   = sts_o.idx_last;
      end
      default: kind_d = bfsc_pkg::KIND_MISS;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_bytes_q  <= in_bytes_i;
      req_handle_q <= in_handle_i;
    end
    cmp_idx_q <= idx_q;
    if (cmp_vld_q && better) begin
      best_idx_q <= cmp_idx_q;
      fit_size_q <= cand_size;
    end
    if (cmd_i.emit) begin
      out_kind_q   <= kind_d;
      out_handle_q <= handle_d;
      out_bytes_q  <= bytes_d;
      out_last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= bfsc_pkg::CAP_RESET;
      used_q      <= '0;
      held_q      <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        found_q <= 1'b0;
      end else if (cmp_vld_q && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        case (cmd_i.res)
          bfsc_pkg::RES_TAKE: begin
            if (found_q) begin
              used_q <= used_q - CW'(1);
              held_q <= held_q - fit_size_q;
            end
          end
          bfsc_pkg::RES_PUT: begin
            if (!reject) begin
              used_q <= used_q + CW'(1);
              held_q <= put_sum[31:0];
            end
          end
          bfsc_pkg::RES_DRAIN: begin
            if (sts_o.idx_last) begin
              used_q <= '0;
              held_q <= '0;
            end
          end
          default: used_q <= used_q;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_handle_o = out_handle_q;
  assign out_bytes_o  = out_bytes_q;
  assign out_last_o   = out_last_q;

  `BFSC_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= CW'(bfsc_pkg::ENTRIES), "slot count over depth")
  `BFSC_ASSERT(a_empty_no_bytes, clk_i, rst_ni, (used_q != '0) || (held_q == '0), "bytes held with no slabs")
  `BFSC_ASSERT(a_emit_free, clk_i, rst_ni, !cmd_i.emit || sts_o.out_free, "result loaded over a pending one")
  `BFSC_ASSERT_NEXT(a_hit_fits, clk_i, rst_ni, cmd_i.emit && (kind_d == bfsc_pkg::KIND_HIT), out_bytes_q >= req_bytes_q, "hit smaller than request")

endmodule

FILE: test/best_fit_slab_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// best_fit_slab_cache_unit_tb
// Self-checking bench for the best-fit slab cache: a directed table covering
// the cap edges, ties, full and empty bins and the unused request code,
// followed by random traffic under four idle/stall phases and a long output
// hold-off. Every result transfer is checked against the in-bench model or, for typed rows, the row's expectation.
// ----------------------------------------------------------------------------
module best_fit_slab_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 75;   // counted requests per random phase
  localparam int BURST_ITEMS  = 16;   // requests offered during the hold-off
  localparam int HOLD_CYCLES  = 400;  // receiver hold-off length
  localparam int SETTLE       = 40;   // covers a full drain or an ignored code
  localparam int QUIET_LIMIT  = 4000; // cycles without any transfer

  // idle/stall percentages per phase: none, sender, receiver, both
  localparam int SEND_IDLE  [PHASES] = '{0, 80, 0, 16};
  localparam int RECV_STALL [PHASES] = '{0, 0, 80, 16};

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] handle;
    logic [31:0] size;
    logic        last;
  } slab_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  // one directed row; for ROW_CFG the cap value travels in bytes
  typedef struct packed {
    row_op_e     op;
    logic [1:0]  func;
    logic [31:0] bytes;
    logic [31:0] handle;
    logic        typed;       // expected result given below, single result
    logic [2:0]  want_kind;
    logic [31:0] want_handle;
    logic [31:0] want_bytes;
  } stim_row_t;

  localparam int DIR_ROWS = 27;

  // Directed rows. Reset cap is 16 MiB; the early puts land exactly on it.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // empty bin: take misses, drain returns nothing, unused code ignored
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'h0000_0000, 32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_DRAIN,  32'h0000_0000, 32'h0000_0000, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, FUNC_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    // zero-size slab, then fill right up to the cap
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      bfsc_pkg::KIND_STORED, 32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h00FF_FFFF, 32'h0000_0001, 1'b1,
      bfsc_pkg::KIND_STORED, 32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h0000_0002, 32'h0000_0002, 1'b1,
      bfsc_pkg::KIND_REJECT, 32'h0000_0002, 32'h0000_0002},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h0000_0001, 32'h0000_0003, 1'b1,
      bfsc_pkg::KIND_STORED, 32'h0, 32'h0},
    // held + size would wrap in 32 bits; must still be rejected
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1,
      bfsc_pkg::KIND_REJECT, 32'hAAAA_AAAA, 32'hFFFF_FFFF},
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'h0000_0000, 32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_HIT,    32'hFFFF_FFFF, 32'h0000_0000},
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'h0000_0002, 32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_HIT,    32'h0000_0001, 32'h00FF_FFFF},
    '{ROW_ITEM, bfsc_pkg::FUNC_DRAIN,  32'h0000_0000, 32'h0000_0000, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    // widest cap, then fill all eight slots with ties on 32 and 64
    '{ROW_CFG,  bfsc_pkg::FUNC_TAKE,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd64,        32'h0000_0010, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd32,        32'h0000_0011, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd32,        32'h0000_0012, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd128,       32'h0000_0013, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd16,        32'h0000_0014, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h8000_0000, 32'h0000_0015, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd64,        32'h0000_0016, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd8,         32'h0000_0017, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    // full bin rejects
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'd5,         32'h0000_0055, 1'b1,
      bfsc_pkg::KIND_REJECT, 32'h0000_0055, 32'd5},
    // ties: lowest slot wins
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'd32,        32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_HIT,    32'h0000_0011, 32'd32},
    '{ROW_ITEM, bfsc_pkg::FUNC_TAKE,   32'd33,        32'h0000_0000, 1'b1,
      bfsc_pkg::KIND_HIT,    32'h0000_0010, 32'd64},
    // cap dropped below what is held: bin keeps its slabs, puts rejected
    '{ROW_CFG,  bfsc_pkg::FUNC_TAKE,   32'h0000_0000, 32'h0000_0000, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0},
    '{ROW_ITEM, bfsc_pkg::FUNC_PUT,    32'h0000_0000, 32'h0000_0099, 1'b1,
      bfsc_pkg::KIND_REJECT, 32'h0000_0099, 32'h0000_0000},
    '{ROW_ITEM, bfsc_pkg::FUNC_DRAIN,  32'h0000_0000, 32'h0000_0000, 1'b0,
      bfsc_pkg::KIND_MISS,   32'h0, 32'h0}
  };

  // DUT signals; every input known from time zero
  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [31:0] cfg_wdata_i    = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata   = '0;
  logic [1:0]  s_axis_tuser   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Bench copy of the bin
  logic [31:0] bin_handle [bfsc_pkg::ENTRIES];
  logic [31:0] bin_size   [bfsc_pkg::ENTRIES];
  int unsigned bin_count;
  logic [31:0] bin_held;
  logic [31:0] bin_cap;

  slab_result_t slab_results_due [$];  // results not yet seen on m_axis

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_tgl     = 1'b0;  // flipped by the stimulus to start a hold-off

  best_fit_slab_cache_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] slab_bytes, [63:32] block_handle
    .s_axis_tuser  (s_axis_tuser),   // [1:0] func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] out_handle, [63:32] out_bytes
    .m_axis_tuser  (m_axis_tuser),   // [2:0] kind
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bin model: applies one accepted request and queues the results it causes.
  // --------------------------------------------------------------------------
  function automatic void predict_slab_results(input logic [1:0] func,
                                               input logic [31:0] bytes,
                                               input logic [31:0] handle);
    bit          found;
    int unsigned best;
    logic [31:0] fit_bytes;
    case (func)
      bfsc_pkg::FUNC_TAKE: begin
        found = 1'b0;
        best = 0;
        fit_bytes = '0;
        // smallest slab that fits; strict < keeps the lowest slot on a tie
        for (int unsigned i = 0; i < bin_count; i++) begin
          if (bin_size[i] >= bytes && (!found || bin_size[i] < fit_bytes)) begin
            found = 1'b1;
            best = i;
            fit_bytes = bin_size[i];
          end
        end
        if (!found) begin
          slab_results_due.push_back('{bfsc_pkg::KIND_MISS, 32'd0, 32'd0, 1'b1});
        end else begin
          slab_results_due.push_back('{bfsc_pkg::KIND_HIT, bin_handle[best], fit_bytes,
                                       1'b1});
          bin_held = bin_held - fit_bytes;
          bin_count--;
          // last slot fills the hole
          bin_handle[best] = bin_handle[bin_count];
          bin_size[best] = bin_size[bin_count];
        end
      end
      bfsc_pkg::FUNC_PUT: begin
        // 33-bit sum so the cap test cannot wrap
        if (bin_count >= bfsc_pkg::ENTRIES ||
            ({1'b0, bin_held} + {1'b0, bytes}) > {1'b0, bin_cap}) begin
          slab_results_due.push_back('{bfsc_pkg::KIND_REJECT, handle, bytes, 1'b1});
        end else begin
          bin_handle[bin_count] = handle;
          bin_size[bin_count] = bytes;
          bin_count++;
          bin_held = bin_held + bytes;
          slab_results_due.push_back('{bfsc_pkg::KIND_STORED, 32'd0, 32'd0, 1'b1});
        end
      end
      bfsc_pkg::FUNC_DRAIN: begin
        for (int unsigned i = 0; i < bin_count; i++) begin
          slab_results_due.push_back('{bfsc_pkg::KIND_DRAIN, bin_handle[i], bin_size[i],
                                       i + 1 == bin_count});
        end
        bin_count = 0;
        bin_held = '0;
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  // Random request: mostly puts and takes so the bin moves between empty and
  // full; takes often ask for a size already cached to hit exact fits/ties.
  function automatic void pick_request(output logic [1:0] func,
                                       output logic [31:0] bytes,
                                       output logic [31:0] handle);
    int r;
    int s;
    r = $urandom_range(99);
    s = $urandom_range(99);
    handle = $urandom;
    if (r < 4)       func = FUNC_UNUSED;
    else if (r < 12) func = bfsc_pkg::FUNC_DRAIN;
    else if (r < 62) func = bfsc_pkg::FUNC_PUT;
    else             func = bfsc_pkg::FUNC_TAKE;

    if (s < 10)      bytes = 32'd0;
    else if (s < 15) bytes = 32'hFFFF_FFFF;
    else if (s < 30) bytes = $urandom;
    else if (s < 45) bytes = 32'd16 << $urandom_range(3);
    else             bytes = $urandom_range(2048, 1);

    if (func == bfsc_pkg::FUNC_TAKE && bin_count != 0 && $urandom_range(99) < 35) begin
      bytes = bin_size[$urandom_range(bin_count - 1)];
      if (bytes != 0 && $urandom_range(1)) bytes = bytes - 1;
    end
  endfunction

  // Offers one request and returns in the step of its transfer, tvalid high.
  task automatic offer_request(input logic [1:0] func, input logic [31:0] bytes,
                               input logic [31:0] handle);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, bytes};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic run_request(input logic [1:0] func, input logic [31:0] bytes,
                             input logic [31:0] handle);
    offer_request(func, bytes, handle);
    predict_slab_results(func, bytes, handle);
  endtask

  // Cap write only with the block idle: all results back, then a settle
  // window in case the last request was one that produced nothing.
  task automatic write_cap(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (slab_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bin_cap = value;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [1:0]  func;
    logic [31:0] bytes;
    logic [31:0] handle;
    logic [31:0] phase_cap;
    int          counted;

    bin_count = 0;
    bin_held  = '0;
    bin_cap   = bfsc_pkg::CAP_RESET;

    // single reset at the start
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed rows queue the expectation written in the row;
    // the model still runs so its state follows the block.
    for (int n = 0; n < DIR_ROWS; n++) begin
      if (DIRECTED[n].op == ROW_CFG) begin
        write_cap(DIRECTED[n].bytes);
      end else begin
        run_request(DIRECTED[n].func, DIRECTED[n].bytes, DIRECTED[n].handle);
        if (DIRECTED[n].typed) begin
          void'(slab_results_due.pop_back());
          slab_results_due.push_back('{DIRECTED[n].want_kind, DIRECTED[n].want_handle,
                                       DIRECTED[n].want_bytes, 1'b1});
        end
      end
    end

    // Random phases, each under its own cap and idle/stall mix. The cap is
    // written with whatever the bin holds, so it often lands below held bytes.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_cap = 32'hFFFF_FFFF;
        1:       phase_cap = 32'd4096;
        2:       phase_cap = bfsc_pkg::CAP_RESET;
        default: phase_cap = $urandom_range(3000);
      endcase
      write_cap(phase_cap);
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];

      if (p == 0) begin
        // back pressure: output held off while requests keep coming, so the
        // result register fills and tready drops on the request side
        hold_tgl <= ~hold_tgl;
        for (int k = 0; k < BURST_ITEMS; k++) begin
          pick_request(func, bytes, handle);
          run_request(func, bytes, handle);
        end
      end

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick_request(func, bytes, handle);
        run_request(func, bytes, handle);
        if (func != FUNC_UNUSED) counted++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain out, then let the block settle before the verdict
    while (slab_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side ready: random stalls per phase, plus a hold-off counted here
  // whenever the stimulus flips hold_tgl.
  // --------------------------------------------------------------------------
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen     <= hold_tgl;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each result transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    slab_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (slab_results_due.size() == 0) begin
        $error("unexpected result transfer: kind %0d handle %h bytes %h last %b",
               m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
        mismatches++;
      end else begin
        want = slab_results_due.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[31:0] !== want.handle) begin
          $error("out_handle: expected %h, got %h", want.handle, m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[63:32] !== want.size) begin
          $error("out_bytes: expected %h, got %h", want.size, m_axis_tdata[63:32]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either channel ends the run.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bfsc_pkg.sv
rtl/bfsc_ctrl.sv
rtl/bfsc_dp.sv
rtl/best_fit_slab_cache_unit.sv
test/best_fit_slab_cache_unit_tb.sv
